// ===== rtl/core/dotq_pkg.sv =====
// ----------------------------------------------------------------------------
// dotq_pkg
// Types and codes shared by the deadline ordered timer queue.
// ----------------------------------------------------------------------------
package dotq_pkg;

   localparam int QueueDepth = 16;
   localparam int IdxWidth   = $clog2(QueueDepth);
   localparam int RidWidth   = 4;
   localparam int TimeWidth  = 32;
   localparam int MaxFire    = 16;

   localparam logic [2:0] FUNC_ADD_ABS = 3'd0;
   localparam logic [2:0] FUNC_ADD_DLY = 3'd1;
   localparam logic [2:0] FUNC_ADD_REP = 3'd2;
   localparam logic [2:0] FUNC_CANCEL  = 3'd3;
   localparam logic [2:0] FUNC_TICK    = 3'd4;

   localparam logic [1:0] KIND_FIRED  = 2'd0;
   localparam logic [1:0] KIND_REPID  = 2'd1;
   localparam logic [1:0] KIND_ACCEPT = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   typedef struct packed {
      logic [2:0]           func;
      logic [TimeWidth-1:0] time_value;
      logic [15:0]          repeat_count;
      logic [15:0]          task_tag;
      logic [RidWidth-1:0]  cancel_id;
   } req_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [15:0]         fired_tag;
      logic [RidWidth-1:0] repeat_id;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [TimeWidth-1:0] deadline;
      logic [15:0]          tag;
      logic                 is_repeat;
      logic [RidWidth-1:0]  rid;
      logic [15:0]          remaining;
      logic [TimeWidth-1:0] interval;
      logic [15:0]          order;
   } entry_type;

endpackage

// ===== rtl/core/dotq_entry_ram.sv =====
// ----------------------------------------------------------------------------
// dotq_entry_ram
// Entry store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dotq_entry_ram (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [dotq_pkg::IdxWidth-1:0]       wr_addr,
   input  dotq_pkg::entry_type                 wr_data,
   input  logic [dotq_pkg::IdxWidth-1:0]       rd_addr,
   output dotq_pkg::entry_type                 rd_data
);

   dotq_pkg::entry_type mem [dotq_pkg::QueueDepth];
   dotq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/deadline_ordered_timer_queue.sv =====
// ----------------------------------------------------------------------------
// deadline_ordered_timer_queue
// Tick driven timer queue that fires pending events in deadline order.
// ----------------------------------------------------------------------------
//  channel  direction  payload    handshake
//  req_     in         req_type   req_valid / req_ready
//  rsp_     out        rsp_type   rsp_valid / rsp_ready
//
// Adds and cancels answer with one transaction.
// A tick scans the entry memory once per fired event, up to MaxFire events,
// and, if that limit is not reached, once more to find that nothing is left due.
// Reset is synchronous and clears the control state and valid flags only.
// A stalled result port holds the tick at its fire and flush steps until the output register drains.
// ----------------------------------------------------------------------------
module deadline_ordered_timer_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  dotq_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dotq_pkg::rsp_type   rsp_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FIRE  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;
   localparam int CntWidth  = dotq_pkg::IdxWidth + 1;
   localparam int FireWidth = $clog2(dotq_pkg::MaxFire + 1);

   logic [1:0] state_ff, state_in;
   logic [dotq_pkg::TimeWidth-1:0] tick_ff, tick_in;
   logic [dotq_pkg::QueueDepth-1:0] valid_ff, valid_in;
   logic [15:0] active_ff, active_in;
   logic [dotq_pkg::RidWidth-1:0] next_rid_ff, next_rid_in;
   logic [15:0] seq_ff, seq_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic dv_ff, dv_in;
   logic [dotq_pkg::IdxWidth-1:0] didx_ff, didx_in;
   logic found_ff, found_in;
   dotq_pkg::entry_type best_ff, best_in;
   logic [dotq_pkg::IdxWidth-1:0] best_idx_ff, best_idx_in;
   logic [FireWidth-1:0] nfire_ff, nfire_in;
   logic held_ff, held_in;
   dotq_pkg::rsp_type held_data_ff, held_data_in;
   logic rsp_valid_ff, rsp_valid_in;
   dotq_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic wr_en;
   logic [dotq_pkg::IdxWidth-1:0] wr_addr;
   dotq_pkg::entry_type wr_data;
   dotq_pkg::entry_type rd_data;

   logic out_free;
   logic full;
   logic [dotq_pkg::IdxWidth-1:0] free_idx;
   logic cand_due;
   logic cand_before;
   logic [15:0] order_diff;
   logic rearm;
   logic [15:0] cnt_fix;
   logic [dotq_pkg::TimeWidth-1:0] tv_fix;

   dotq_entry_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (cnt_ff[dotq_pkg::IdxWidth-1:0]),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      full     = 1'b1;
      free_idx = '0;
      for (int i = dotq_pkg::QueueDepth - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            full     = 1'b0;
            free_idx = dotq_pkg::IdxWidth'(i);
         end
      end
   end

   assign order_diff  = rd_data.order - best_ff.order;
   assign cand_due    = valid_ff[didx_ff] && (rd_data.deadline <= tick_ff);
   assign cand_before = (rd_data.deadline < best_ff.deadline) ||
                        ((rd_data.deadline == best_ff.deadline) && order_diff[15]);
   assign rearm       = best_ff.is_repeat && active_ff[best_ff.rid] &&
                        (best_ff.remaining != 16'd0);
   assign cnt_fix     = (req_data.repeat_count == 16'd0) ? 16'd1 : req_data.repeat_count;
   assign tv_fix      = (req_data.time_value == '0) ? dotq_pkg::TimeWidth'(1)
                                                    : req_data.time_value;

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      valid_in     = valid_ff;
      active_in    = active_ff;
      next_rid_in  = next_rid_ff;
      seq_in       = seq_ff;
      cnt_in       = cnt_ff;
      dv_in        = 1'b0;
      didx_in      = didx_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      nfire_in     = nfire_ff;
      held_in      = held_ff;
      held_data_in = held_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = free_idx;
      wr_data      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               priority case (req_data.func)
                  dotq_pkg::FUNC_ADD_ABS, dotq_pkg::FUNC_ADD_DLY: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_data_in = '{dotq_pkg::KIND_REJECT, 16'd0, '0, 1'b1};
                     end else begin
                        wr_en            = 1'b1;
                        wr_data.deadline = (req_data.func == dotq_pkg::FUNC_ADD_ABS) ?
                                           req_data.time_value :
                                           tick_ff + req_data.time_value;
                        wr_data.tag      = req_data.task_tag;
                        wr_data.order    = seq_ff;
                        valid_in[free_idx] = 1'b1;
                        seq_in           = seq_ff + 16'd1;
                        rsp_data_in = '{dotq_pkg::KIND_ACCEPT, 16'd0, '0, 1'b1};
                     end
                  end
                  dotq_pkg::FUNC_ADD_REP: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_data_in = '{dotq_pkg::KIND_REJECT, 16'd0, '0, 1'b1};
                     end else begin
                        wr_en             = 1'b1;
                        wr_data.deadline  = tick_ff + tv_fix;
                        wr_data.tag       = req_data.task_tag;
                        wr_data.is_repeat = 1'b1;
                        wr_data.rid       = next_rid_ff;
                        wr_data.remaining = cnt_fix - 16'd1;
                        wr_data.interval  = tv_fix;
                        wr_data.order     = seq_ff;
                        valid_in[free_idx] = 1'b1;
                        seq_in            = seq_ff + 16'd1;
                        active_in[next_rid_ff] = 1'b1;
                        next_rid_in       = next_rid_ff + 1'b1;
                        rsp_data_in = '{dotq_pkg::KIND_REPID, 16'd0, next_rid_ff, 1'b1};
                     end
                  end
                  dotq_pkg::FUNC_CANCEL: begin
                     active_in[req_data.cancel_id] = 1'b0;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{dotq_pkg::KIND_ACCEPT, 16'd0, '0, 1'b1};
                  end
                  dotq_pkg::FUNC_TICK: begin
                     tick_in  = tick_ff + 1'b1;
                     state_in = ST_SCAN;
                     cnt_in   = '0;
                     found_in = 1'b0;
                     nfire_in = '0;
                     held_in  = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!cnt_ff[CntWidth-1]) begin
               cnt_in  = cnt_ff + 1'b1;
               dv_in   = 1'b1;
               didx_in = cnt_ff[dotq_pkg::IdxWidth-1:0];
            end
            if (dv_ff) begin
               if (cand_due && (!found_ff || cand_before)) begin
                  found_in    = 1'b1;
                  best_in     = rd_data;
                  best_idx_in = didx_ff;
               end
               if (didx_ff == dotq_pkg::IdxWidth'(dotq_pkg::QueueDepth - 1)) begin
                  state_in = (found_ff || cand_due) ? ST_FIRE : ST_FLUSH;
               end
            end
         end
         ST_FIRE: begin
            if (!held_ff || out_free) begin
               if (held_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = held_data_ff;
               end
               held_in      = 1'b1;
               held_data_in = '{dotq_pkg::KIND_FIRED, best_ff.tag, best_ff.rid, 1'b0};
               valid_in[best_idx_ff] = 1'b0;
               if (rearm) begin
                  wr_en             = 1'b1;
                  wr_addr           = best_idx_ff;
                  wr_data           = best_ff;
                  wr_data.deadline  = tick_ff + best_ff.interval;
                  wr_data.remaining = best_ff.remaining - 16'd1;
                  wr_data.order     = seq_ff;
                  valid_in[best_idx_ff] = 1'b1;
                  seq_in            = seq_ff + 16'd1;
               end
               nfire_in = nfire_ff + 1'b1;
               cnt_in   = '0;
               found_in = 1'b0;
               state_in = (nfire_ff == FireWidth'(dotq_pkg::MaxFire - 1)) ?
                          ST_FLUSH : ST_SCAN;
            end
         end
         ST_FLUSH: begin
            if (!held_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_data_in      = held_data_ff;
               rsp_data_in.last = 1'b1;
               held_in          = 1'b0;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         valid_ff     <= '0;
         active_ff    <= '0;
         next_rid_ff  <= '0;
         seq_ff       <= '0;
         cnt_ff       <= '0;
         dv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         nfire_ff     <= '0;
         held_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         valid_ff     <= valid_in;
         active_ff    <= active_in;
         next_rid_ff  <= next_rid_in;
         seq_ff       <= seq_in;
         cnt_ff       <= cnt_in;
         dv_ff        <= dv_in;
         found_ff     <= found_in;
         nfire_ff     <= nfire_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      didx_ff      <= didx_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      held_data_ff <= held_data_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule
